/* hw/rtl/sces_pkg.sv */
// ----------------------------------------------------------------------------
// Spring chain Euler step package
// Shared types, register codes, reset values and fixed-point helpers for the
// spring chain integrator.
// ----------------------------------------------------------------------------
package sces_pkg;

  localparam int unsigned MAX_PARTICLES_DEFAULT = 16;

  localparam logic [15:0] SPRING_CONSTANT_RESET = 16'd6554;
  localparam logic [15:0] INVERSE_MASS_RESET    = 16'd6554;
  localparam logic [15:0] TIME_STEP_RESET       = 16'd66;
  localparam logic [30:0] WALL_LENGTH_RESET     = 31'd655360;
  localparam logic [4:0]  PARTICLES_USED_RESET  = 5'd10;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 31;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPRING_CONSTANT = 3'd0,
    CFG_INVERSE_MASS    = 3'd1,
    CFG_TIME_STEP       = 3'd2,
    CFG_WALL_LENGTH     = 3'd3,
    CFG_PARTICLES_USED  = 3'd4
  } cfg_index_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOADX,
    ST_FETCH,
    ST_READ,
    ST_DIFF,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic               op;
    logic [3:0]         particle_index;
    logic signed [31:0] position;
    logic signed [31:0] momentum;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_position;
    logic signed [31:0] out_momentum;
    logic               last_particle;
  } out_t;

  // Product scaled by a Q0.16 factor, rounded half up.
  function automatic logic signed [36:0] round_q16(input logic signed [52:0] prod);
    logic signed [52:0] biased;
    biased = prod + 53'sd32768;
    return biased[52:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] res;
    if (v > 38'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/sces_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sces_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/spring_chain_euler_step.sv */
// ----------------------------------------------------------------------------
// Spring chain Euler step
// Mass-spring chain between two walls, advanced by one explicit Euler sweep
// per step beat, with one shared 36 by 17 bit multiplier.
// ----------------------------------------------------------------------------
// A load beat is written at acceptance if its index is in range and yields
// no result; the input stays open. A step beat closes the input through
// LOADX and FETCH and then READ, DIFF, M1 to M4 and UPD per particle; each
// result is registered in UPD, which waits while the output register holds
// an untaken result. The shared multiplier is used four times per
// particle. Reset restores the register defaults and idles the sequencer;
// particle memories are not cleared and must be loaded before a step.
module spring_chain_euler_step #(
  parameter int unsigned MAX_PARTICLES = sces_pkg::MAX_PARTICLES_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sces_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [sces_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  sces_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sces_pkg::out_t                       out_data_o
);

  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

  // Configuration registers.
  logic [15:0] k_q, im_q, dt_q;
  logic [30:0] wall_q;
  logic [4:0]  pu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= sces_pkg::SPRING_CONSTANT_RESET;
      im_q   <= sces_pkg::INVERSE_MASS_RESET;
      dt_q   <= sces_pkg::TIME_STEP_RESET;
      wall_q <= sces_pkg::WALL_LENGTH_RESET;
      pu_q   <= sces_pkg::PARTICLES_USED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sces_pkg::CFG_SPRING_CONSTANT: k_q    <= cfg_wdata_i[15:0];
        sces_pkg::CFG_INVERSE_MASS:    im_q   <= cfg_wdata_i[15:0];
        sces_pkg::CFG_TIME_STEP:       dt_q   <= cfg_wdata_i[15:0];
        sces_pkg::CFG_WALL_LENGTH:     wall_q <= cfg_wdata_i[30:0];
        sces_pkg::CFG_PARTICLES_USED:  pu_q   <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  sces_pkg::state_e state_q, state_d;
  logic [CW-1:0]    i_q, i_d, n_q, n_d, nxt_i;
  logic             out_valid_q, out_valid_d;
  sces_pkg::out_t   out_q;

  logic signed [31:0] x_q, xr_q, left_q, p_q, pn_q, vel_q;
  logic signed [35:0] diff_q, grad_q;
  logic signed [52:0] prod_q, prod_d;
  logic signed [35:0] mul_a;
  logic [15:0]        mul_f;
  logic signed [36:0] rnd_v;
  logic signed [31:0] right_v, xn_v, pn_v;
  logic signed [35:0] diff_v;

  logic            in_acc, is_last, out_free, load_ok;
  logic [AW+3:0]   load_idx_ext;
  logic [AW-1:0]   load_addr;

  logic            pos_we, mom_we;
  logic [AW-1:0]   pos_waddr, pos_raddr, mom_raddr;
  logic [31:0]     pos_wdata, mom_wdata, pos_rdata, mom_rdata;

  assign in_acc       = in_valid_i && in_ready_o;
  assign nxt_i        = i_q + CW'(1);
  assign is_last      = (nxt_i == n_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign load_idx_ext = (AW + 4)'(in_data_i.particle_index);
  assign load_addr    = load_idx_ext[AW-1:0];
  assign load_ok      = (32'(in_data_i.particle_index) < MAX_PARTICLES);

  always_comb begin
    if (pu_q == 5'd0) begin
      n_d = CW'(1);
    end else if (32'(pu_q) > MAX_PARTICLES) begin
      n_d = CW'(MAX_PARTICLES);
    end else begin
      n_d = CW'(pu_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sces_pkg::ST_IDLE: begin
        if (in_acc && in_data_i.op == sces_pkg::OP_STEP) begin
          state_d = sces_pkg::ST_LOADX;
        end
      end
      sces_pkg::ST_LOADX: state_d = sces_pkg::ST_FETCH;
      sces_pkg::ST_FETCH: state_d = sces_pkg::ST_READ;
      sces_pkg::ST_READ:  state_d = sces_pkg::ST_DIFF;
      sces_pkg::ST_DIFF:  state_d = sces_pkg::ST_M1;
      sces_pkg::ST_M1:    state_d = sces_pkg::ST_M2;
      sces_pkg::ST_M2:    state_d = sces_pkg::ST_M3;
      sces_pkg::ST_M3:    state_d = sces_pkg::ST_M4;
      sces_pkg::ST_M4:    state_d = sces_pkg::ST_UPD;
      sces_pkg::ST_UPD: begin
        if (out_free) begin
          state_d = is_last ? sces_pkg::ST_IDLE : sces_pkg::ST_READ;
        end
      end
      default: state_d = sces_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    pos_we     = 1'b0;
    mom_we     = 1'b0;
    pos_waddr  = i_q[AW-1:0];
    pos_wdata  = xn_v;
    mom_wdata  = pn_q;
    pos_raddr  = nxt_i[AW-1:0];
    mom_raddr  = i_q[AW-1:0];
    mul_a      = diff_q;
    mul_f      = k_q;
    unique case (state_q)
      sces_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        pos_waddr  = load_addr;
        pos_wdata  = in_data_i.position;
        mom_wdata  = in_data_i.momentum;
        if (in_acc && in_data_i.op == sces_pkg::OP_LOAD && load_ok) begin
          pos_we = 1'b1;
          mom_we = 1'b1;
        end
      end
      sces_pkg::ST_LOADX: pos_raddr = '0;
      sces_pkg::ST_M2: begin
        mul_a = {{4{p_q[31]}}, p_q};
        mul_f = im_q;
      end
      sces_pkg::ST_M3: begin
        mul_a = grad_q;
        mul_f = dt_q;
      end
      sces_pkg::ST_M4: begin
        mul_a = {{4{vel_q[31]}}, vel_q};
        mul_f = dt_q;
      end
      sces_pkg::ST_UPD: begin
        mul_a  = {{4{vel_q[31]}}, vel_q};
        mul_f  = dt_q;
        pos_we = out_free;
        mom_we = out_free;
      end
      default: ;
    endcase
  end

  assign prod_d  = mul_a * $signed({1'b0, mul_f});
  assign rnd_v   = sces_pkg::round_q16(prod_q);
  assign right_v = is_last ? $signed({1'b0, wall_q}) : $signed(pos_rdata);
  assign diff_v  = $signed({{3{x_q[31]}}, x_q, 1'b0}) - {{4{left_q[31]}}, left_q}
                   - {{4{right_v[31]}}, right_v};
  assign pn_v    = sces_pkg::sat32({{6{p_q[31]}}, p_q} - {rnd_v[36], rnd_v});
  assign xn_v    = sces_pkg::sat32({{6{x_q[31]}}, x_q} + {rnd_v[36], rnd_v});

  always_comb begin
    i_d = i_q;
    if (state_q == sces_pkg::ST_IDLE) begin
      i_d = '0;
    end else if (state_q == sces_pkg::ST_UPD && out_free) begin
      i_d = nxt_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == sces_pkg::ST_UPD && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sces_pkg::ST_IDLE;
      i_q         <= '0;
      n_q         <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        n_q <= n_d;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      sces_pkg::ST_IDLE:  left_q <= '0;
      sces_pkg::ST_FETCH: x_q    <= pos_rdata;
      sces_pkg::ST_DIFF: begin
        p_q    <= mom_rdata;
        xr_q   <= right_v;
        diff_q <= diff_v;
      end
      sces_pkg::ST_M2: grad_q <= rnd_v[35:0];
      sces_pkg::ST_M3: vel_q  <= rnd_v[31:0];
      sces_pkg::ST_M4: pn_q   <= pn_v;
      sces_pkg::ST_UPD: begin
        if (out_free) begin
          left_q              <= xn_v;
          x_q                 <= xr_q;
          out_q.out_index     <= 4'(i_q);
          out_q.out_position  <= xn_v;
          out_q.out_momentum  <= pn_q;
          out_q.last_particle <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sces_ram #(
    .WIDTH(32),
    .DEPTH(MAX_PARTICLES)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(pos_waddr),
    .wdata_i(pos_wdata),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  sces_ram #(
    .WIDTH(32),
    .DEPTH(MAX_PARTICLES)
  ) u_mom_ram (
    .clk_i  (clk_i),
    .we_i   (mom_we),
    .waddr_i(pos_waddr),
    .wdata_i(mom_wdata),
    .raddr_i(mom_raddr),
    .rdata_o(mom_rdata)
  );

endmodule
